/* hdl/sparse_polynomial_merge_add_macros.svh */
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: assertion macros
// Concurrent checks with an asynchronous active-low reset disable.
// -----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_MERGE_ADD_MACROS_SVH
`define SPARSE_POLYNOMIAL_MERGE_ADD_MACROS_SVH
`ifndef ASSERT_OFF
`define SPMA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SPMA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SPMA_ASSERT(lbl, clk, rstn, prop, msg)
`define SPMA_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* hdl/spma_pkg.sv */
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: package
// Opcodes, sequencer states and the stored term type.
// -----------------------------------------------------------------------------
package spma_pkg;

  localparam int unsigned CoefW    = 16;
  localparam int unsigned SumW     = 17;
  localparam int unsigned PowerW   = 8;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic        [PowerW-1:0] power;
  } term_t;

endpackage

/* hdl/spma_req_if.sv */
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: request channel
// Valid/ready channel carrying one load or run request.
// -----------------------------------------------------------------------------
interface spma_req_if;
  logic                                      valid;
  logic                                      ready;
  logic [1:0]                                opcode;
  logic signed [spma_pkg::CoefW-1:0]         coef_in;
  logic        [spma_pkg::PowerW-1:0]        power_in;

  modport source (output valid, output opcode, output coef_in, output power_in, input ready);
  modport sink   (input valid, input opcode, input coef_in, input power_in, output ready);
endinterface

/* hdl/spma_rsp_if.sv */
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: result channel
// Valid/ready channel carrying one term of the sum.
// -----------------------------------------------------------------------------
interface spma_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [spma_pkg::SumW-1:0]    coef_out;
  logic        [spma_pkg::PowerW-1:0]  power_out;
  logic                                is_last;
  logic                                is_empty;
  logic                                overflow;

  modport source (output valid, output coef_out, output power_out, output is_last,
                  output is_empty, output overflow, input ready);
  modport sink   (input valid, input coef_out, input power_out, input is_last,
                  input is_empty, input overflow, output ready);
endinterface

/* hdl/spma_ram.sv */
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module spma_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/spma_merge.sv */
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: merge sequencer
// Walks both stores, one entry step per cycle unless stalled, emits the sum.
// -----------------------------------------------------------------------------
module spma_merge #(
  parameter int unsigned MAX_TERMS = 16,
  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned CW = $clog2(MAX_TERMS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CW-1:0]       cnt_a_i,
  input  logic [CW-1:0]       cnt_b_i,
  input  logic                ovf_i,
  input  spma_pkg::term_t     rdata_a_i,
  input  spma_pkg::term_t     rdata_b_i,
  output logic [AW-1:0]       raddr_a_o,
  output logic [AW-1:0]       raddr_b_o,
  output logic                busy_o,
  output logic                clear_o,
  spma_rsp_if.source          rsp_o
);

  spma_pkg::state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;

  logic                                p_valid_q, p_valid_d;
  logic signed [spma_pkg::SumW-1:0]    p_coef_q, p_coef_d;
  logic        [spma_pkg::PowerW-1:0]  p_pow_q, p_pow_d;

  logic                                o_valid_q, o_valid_d;
  logic signed [spma_pkg::SumW-1:0]    o_coef_q, o_coef_d;
  logic        [spma_pkg::PowerW-1:0]  o_pow_q, o_pow_d;
  logic                                o_last_q, o_last_d;
  logic                                o_empty_q, o_empty_d;
  logic                                o_ovf_q, o_ovf_d;

  logic                                a_has, b_has, run_done, o_free, stall;
  logic                                take_a, take_b, emit;
  logic signed [spma_pkg::SumW-1:0]    coef_a, coef_b, sum, e_coef;
  logic        [spma_pkg::PowerW-1:0]  e_pow;

  assign a_has    = (i_q < cnt_a_i);
  assign b_has    = (j_q < cnt_b_i);
  assign run_done = !a_has && !b_has;
  assign o_free   = !o_valid_q || rsp_o.ready;
  assign stall    = p_valid_q && !o_free;
  assign coef_a   = {rdata_a_i.coef[spma_pkg::CoefW-1], rdata_a_i.coef};
  assign coef_b   = {rdata_b_i.coef[spma_pkg::CoefW-1], rdata_b_i.coef};
  assign sum      = coef_a + coef_b;

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    emit   = 1'b0;
    e_coef = coef_a;
    e_pow  = rdata_a_i.power;
    if (a_has && b_has) begin
      if (rdata_a_i.power == rdata_b_i.power) begin
        take_a = 1'b1;
        take_b = 1'b1;
        emit   = (sum != '0);
        e_coef = sum;
      end else if (rdata_a_i.power > rdata_b_i.power) begin
        take_a = 1'b1;
        emit   = 1'b1;
      end else begin
        take_b = 1'b1;
        emit   = 1'b1;
        e_coef = coef_b;
        e_pow  = rdata_b_i.power;
      end
    end else if (a_has) begin
      take_a = 1'b1;
      emit   = 1'b1;
    end else if (b_has) begin
      take_b = 1'b1;
      emit   = 1'b1;
      e_coef = coef_b;
      e_pow  = rdata_b_i.power;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      spma_pkg::ST_IDLE: begin
        if (start_i) state_d = spma_pkg::ST_RUN;
      end
      spma_pkg::ST_RUN: begin
        if (run_done) state_d = spma_pkg::ST_FLUSH;
      end
      spma_pkg::ST_FLUSH: begin
        if (o_free) state_d = spma_pkg::ST_IDLE;
      end
      default: state_d = spma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    i_d       = i_q;
    j_d       = j_q;
    p_valid_d = p_valid_q;
    p_coef_d  = p_coef_q;
    p_pow_d   = p_pow_q;
    o_valid_d = o_valid_q && !rsp_o.ready;
    o_coef_d  = o_coef_q;
    o_pow_d   = o_pow_q;
    o_last_d  = o_last_q;
    o_empty_d = o_empty_q;
    o_ovf_d   = o_ovf_q;
    clear_o   = 1'b0;
    case (state_q)
      spma_pkg::ST_IDLE: begin
        if (start_i) begin
          i_d       = '0;
          j_d       = '0;
          p_valid_d = 1'b0;
        end
      end
      spma_pkg::ST_RUN: begin
        if (!stall && !run_done) begin
          if (take_a) i_d = i_q + CW'(1);
          if (take_b) j_d = j_q + CW'(1);
          if (emit) begin
            p_valid_d = 1'b1;
            p_coef_d  = e_coef;
            p_pow_d   = e_pow;
            if (p_valid_q) begin
              o_valid_d = 1'b1;
              o_coef_d  = p_coef_q;
              o_pow_d   = p_pow_q;
              o_last_d  = 1'b0;
              o_empty_d = 1'b0;
              o_ovf_d   = ovf_i;
            end
          end
        end
      end
      spma_pkg::ST_FLUSH: begin
        if (o_free) begin
          o_valid_d = 1'b1;
          o_coef_d  = p_valid_q ? p_coef_q : '0;
          o_pow_d   = p_valid_q ? p_pow_q : '0;
          o_last_d  = 1'b1;
          o_empty_d = !p_valid_q;
          o_ovf_d   = ovf_i;
          p_valid_d = 1'b0;
          clear_o   = 1'b1;
        end
      end
      default: begin
        p_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spma_pkg::ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_coef_q  <= p_coef_d;
    p_pow_q   <= p_pow_d;
    o_coef_q  <= o_coef_d;
    o_pow_q   <= o_pow_d;
    o_last_q  <= o_last_d;
    o_empty_q <= o_empty_d;
    o_ovf_q   <= o_ovf_d;
  end

  assign raddr_a_o       = i_d[AW-1:0];
  assign raddr_b_o       = j_d[AW-1:0];
  assign busy_o          = (state_q != spma_pkg::ST_IDLE);
  assign rsp_o.valid     = o_valid_q;
  assign rsp_o.coef_out  = o_coef_q;
  assign rsp_o.power_out = o_pow_q;
  assign rsp_o.is_last   = o_last_q;
  assign rsp_o.is_empty  = o_empty_q;
  assign rsp_o.overflow  = o_ovf_q;

endmodule

/* hdl/sparse_polynomial_merge_add.sv */
// Load request: accepted whenever no merge is in progress.
// Run request: at most count A + count B merge steps, each limited by the single read port
// of each term RAM, then an end-detect step and a flush step; output stalls hold the walk.
// Results: each term is held in a pending register and moves to the output register when
// the next term is emitted or, for the last term, at the flush; cancelled sums emit nothing.
// Reset clears both counts and the overflow flag; term RAM contents stay undefined until loaded.
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: top level
// Term stores with load counters and the merge sequencer.
// -----------------------------------------------------------------------------
`include "sparse_polynomial_merge_add_macros.svh"

module sparse_polynomial_merge_add #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spma_req_if.sink     req_i,
  spma_rsp_if.source   rsp_o
);

  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned TW = $bits(spma_pkg::term_t);

  logic [CW-1:0]   cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic            ovf_q, ovf_d;
  logic            accept, busy, clear, start, load_a, load_b, we_a, we_b;
  logic [AW-1:0]   raddr_a, raddr_b;
  spma_pkg::term_t wterm, rdata_a, rdata_b;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !busy;
  assign load_a      = accept && (req_i.opcode == spma_pkg::OP_LOAD_A);
  assign load_b      = accept && (req_i.opcode == spma_pkg::OP_LOAD_B);
  assign start       = accept && (req_i.opcode == spma_pkg::OP_RUN);
  assign we_a        = load_a && (cnt_a_q < CW'(MAX_TERMS));
  assign we_b        = load_b && (cnt_b_q < CW'(MAX_TERMS));
  assign wterm.coef  = req_i.coef_in;
  assign wterm.power = req_i.power_in;

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ovf_d   = ovf_q;
    if (clear) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
    end else begin
      if (we_a) cnt_a_d = cnt_a_q + CW'(1);
      if (we_b) cnt_b_d = cnt_b_q + CW'(1);
      if ((load_a && !we_a) || (load_b && !we_b)) ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ovf_q   <= ovf_d;
    end
  end

  spma_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (wterm),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  spma_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (wterm),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  spma_merge #(.MAX_TERMS(MAX_TERMS)) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cnt_a_i   (cnt_a_q),
    .cnt_b_i   (cnt_b_q),
    .ovf_i     (ovf_q),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .busy_o    (busy),
    .clear_o   (clear),
    .rsp_o     (rsp_o)
  );

  `SPMA_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, (cnt_a_q > CW'(MAX_TERMS)) || (cnt_b_q > CW'(MAX_TERMS)), "term count beyond store depth")
  `SPMA_ASSERT(a_clear_busy, clk_i, rst_ni, clear |-> busy, "store clear outside a merge")
  `SPMA_ASSERT(a_clear_done, clk_i, rst_ni, clear |=> (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q, "stores not empty after merge")
  `SPMA_ASSERT_NEVER(a_no_write_busy, clk_i, rst_ni, busy && (we_a || we_b), "store write during merge walk")

endmodule

/* verif/sparse_polynomial_merge_add_test.sv */
// -----------------------------------------------------------------------------
// Sparse polynomial merge add: testbench
// Loads term lists A and B and runs merges. The lists come first from a short
// table, then from random polynomial pairs: sorted powers, shared powers,
// cancelling sums, full lists, unsorted lists and ignored opcodes. A local
// model of the two term stores predicts the result terms, save for table rows
// that give their own. Both channels idle at random, except for one stretch without idling.
// -----------------------------------------------------------------------------
module sparse_polynomial_merge_add_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spma_pkg::*;

  localparam int unsigned MaxTerms    = 16;
  localparam int unsigned IdlePct     = 31;
  localparam int unsigned RandomItems = 130;
  localparam int unsigned DrainCycles = 2 * MaxTerms + 16;
  localparam int unsigned MaxReports  = 10;
  localparam logic [1:0]  OpIgnored   = 2'd3;

  typedef struct packed {
    logic signed [SumW-1:0]   coef;
    logic        [PowerW-1:0] power;
    logic                     is_last;
    logic                     is_empty;
    logic                     overflow;
  } sum_term_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoefW-1:0]  coef;
    logic        [PowerW-1:0] power;
    logic                     typed;
    sum_term_t                want;
  } poly_req_t;

  localparam sum_term_t EmptySum = '{17'sd0, 8'd0, 1'b1, 1'b1, 1'b0};
  localparam sum_term_t NoSum    = '0;

  logic clk_i;
  logic rst_ni;

  spma_req_if req_if ();
  spma_rsp_if rsp_if ();

  sparse_polynomial_merge_add #(
    .MAX_TERMS(MaxTerms)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  poly_req_t directed_rows [0:21] = '{
    '{OP_RUN,    16'sh0000, 8'h00, 1'b1, EmptySum},
    '{OpIgnored, 16'shFFFF, 8'hFF, 1'b0, NoSum},
    '{OP_LOAD_A, 16'sh7FFF, 8'hFF, 1'b0, NoSum},
    '{OP_LOAD_B, 16'sh7FFF, 8'hFF, 1'b0, NoSum},
    '{OP_LOAD_A, 16'sh8000, 8'h00, 1'b0, NoSum},
    '{OP_LOAD_B, 16'sh8000, 8'h00, 1'b0, NoSum},
    '{OP_RUN,    16'sh0000, 8'h00, 1'b0, NoSum},
    '{OP_LOAD_A, 16'sh0005, 8'h0A, 1'b0, NoSum},
    '{OP_LOAD_B, 16'shFFFB, 8'h0A, 1'b0, NoSum},
    '{OP_RUN,    16'shFFFF, 8'hFF, 1'b1, EmptySum},
    '{OP_LOAD_A, 16'sh0000, 8'h03, 1'b0, NoSum},
    '{OP_LOAD_B, 16'sh0007, 8'h01, 1'b0, NoSum},
    '{OP_LOAD_A, 16'sh0004, 8'h09, 1'b0, NoSum},
    '{OP_LOAD_B, 16'sh8000, 8'h80, 1'b0, NoSum},
    '{OP_RUN,    16'sh0000, 8'h00, 1'b0, NoSum},
    '{OP_LOAD_B, 16'sh0001, 8'hC8, 1'b0, NoSum},
    '{OP_RUN,    16'sh0000, 8'h00, 1'b0, NoSum},
    '{OP_LOAD_A, 16'sh1234, 8'h40, 1'b0, NoSum},
    '{OP_RUN,    16'sh0000, 8'h00, 1'b0, NoSum},
    '{OP_LOAD_A, 16'shAAAA, 8'h55, 1'b0, NoSum},
    '{OP_LOAD_B, 16'sh5555, 8'hAA, 1'b0, NoSum},
    '{OP_RUN,    16'sh0000, 8'h00, 1'b0, NoSum}
  };

  poly_req_t   stim_q [$];
  sum_term_t   sum_q [$];
  poly_req_t   cur_req;
  term_t       poly_a [MaxTerms];
  term_t       poly_b [MaxTerms];
  int unsigned a_len;
  int unsigned b_len;
  logic        ovf_flag;
  int unsigned issued_cnt;
  int unsigned total_cnt;
  int unsigned accepted_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  logic        calm;

  assign calm = (cycle_cnt >= 100) && (cycle_cnt < 400);

  function automatic sum_term_t mk_term(input logic signed [SumW-1:0] c,
                                        input logic [PowerW-1:0] p);
    sum_term_t s;
    s          = '0;
    s.coef     = c;
    s.power    = p;
    s.overflow = ovf_flag;
    return s;
  endfunction

  task automatic apply_request(input poly_req_t r);
    sum_term_t              run_q [$];
    sum_term_t              s;
    int unsigned            i;
    int unsigned            j;
    logic signed [SumW-1:0] total;
    case (r.op)
      OP_LOAD_A: begin
        if (a_len < MaxTerms) begin
          poly_a[a_len].coef  = r.coef;
          poly_a[a_len].power = r.power;
          a_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (b_len < MaxTerms) begin
          poly_b[b_len].coef  = r.coef;
          poly_b[b_len].power = r.power;
          b_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OP_RUN: begin
        i = 0;
        j = 0;
        while (i < a_len && j < b_len) begin
          if (poly_a[i].power == poly_b[j].power) begin
            total = $signed(poly_a[i].coef) + $signed(poly_b[j].coef);
            if (total != 0) run_q.push_back(mk_term(total, poly_a[i].power));
            i++;
            j++;
          end else if (poly_a[i].power > poly_b[j].power) begin
            run_q.push_back(mk_term($signed(poly_a[i].coef), poly_a[i].power));
            i++;
          end else begin
            run_q.push_back(mk_term($signed(poly_b[j].coef), poly_b[j].power));
            j++;
          end
        end
        for (; i < a_len; i++) run_q.push_back(mk_term($signed(poly_a[i].coef), poly_a[i].power));
        for (; j < b_len; j++) run_q.push_back(mk_term($signed(poly_b[j].coef), poly_b[j].power));
        if (run_q.size() == 0) begin
          s          = mk_term('0, '0);
          s.is_empty = 1'b1;
          run_q.push_back(s);
        end
        run_q[run_q.size()-1].is_last = 1'b1;
        if (r.typed) begin
          sum_q.push_back(r.want);
        end else begin
          foreach (run_q[k]) sum_q.push_back(run_q[k]);
        end
        a_len    = 0;
        b_len    = 0;
        ovf_flag = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic void push_req(input logic [1:0] op, input logic [CoefW-1:0] c,
                                   input logic [PowerW-1:0] p);
    poly_req_t r;
    r       = '0;
    r.op    = op;
    r.coef  = c;
    r.power = p;
    stim_q.push_back(r);
    if (op != OpIgnored) issued_cnt++;
  endfunction

  // Build one pair of term lists on a shared descending power walk (or random powers), then merge.
  task automatic queue_poly_pair();
    term_t a_q [$];
    term_t b_q [$];
    term_t t;
    int    ta;
    int    tb;
    int    cur;
    int    pick;
    bit    big;
    bit    tidy;
    big  = ($urandom_range(99) < 12);
    tidy = ($urandom_range(99) >= 15);
    ta   = big ? $urandom_range(19, 14) : $urandom_range(6, 0);
    tb   = big ? $urandom_range(19, 14) : $urandom_range(6, 0);
    cur  = big ? 255 : $urandom_range(255, 16);
    while ((a_q.size() < ta || b_q.size() < tb) && cur >= 0) begin
      t.power = tidy ? cur[7:0] : 8'($urandom);
      t.coef  = ($urandom_range(15) == 0) ? '0 : 16'($urandom);
      if (a_q.size() >= ta) pick = 1;
      else if (b_q.size() >= tb) pick = 0;
      else pick = $urandom_range(2);
      if (pick != 1) a_q.push_back(t);
      if (pick != 0) begin
        if (pick == 2) t.coef = ($urandom_range(2) == 0) ? -t.coef : 16'($urandom);
        b_q.push_back(t);
      end
      cur -= big ? $urandom_range(3, 1) : $urandom_range(40, 1);
    end
    while (a_q.size() + b_q.size() > 0) begin
      if ($urandom_range(19) == 0) push_req(OpIgnored, 16'($urandom), 8'($urandom));
      if (b_q.size() == 0 || (a_q.size() > 0 && $urandom_range(1) == 0)) begin
        t = a_q.pop_front();
        push_req(OP_LOAD_A, t.coef, t.power);
      end else begin
        t = b_q.pop_front();
        push_req(OP_LOAD_B, t.coef, t.power);
      end
    end
    push_req(OP_RUN, 16'($urandom), 8'($urandom));
  endtask

  task automatic check_term();
    sum_term_t got;
    sum_term_t want;
    got.coef     = rsp_if.coef_out;
    got.power    = rsp_if.power_out;
    got.is_last  = rsp_if.is_last;
    got.is_empty = rsp_if.is_empty;
    got.overflow = rsp_if.overflow;
    if (sum_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("%0t unexpected term: coef %0d power %0d last %0b empty %0b ovf %0b",
                 $realtime, $signed(got.coef), got.power, got.is_last, got.is_empty,
                 got.overflow);
    end else begin
      want = sum_q.pop_front();
      if (got !== want) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t term mismatch: expected coef %0d power %0d last %0b empty %0b ovf %0b, got coef %0d power %0d last %0b empty %0b ovf %0b",
                   $realtime, $signed(want.coef), want.power, want.is_last, want.is_empty,
                   want.overflow, $signed(got.coef), got.power, got.is_last,
                   got.is_empty, got.overflow);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.opcode   <= OP_LOAD_A;
      req_if.coef_in  <= '0;
      req_if.power_in <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_request(cur_req);
        accepted_cnt++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (stim_q.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          cur_req          = stim_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.opcode   <= cur_req.op;
          req_if.coef_in  <= cur_req.coef;
          req_if.power_in <= cur_req.power;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_term();
      rsp_if.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  initial begin
    req_if.valid    = 1'b0;
    req_if.opcode   = OP_LOAD_A;
    req_if.coef_in  = '0;
    req_if.power_in = '0;
    rsp_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    a_len           = 0;
    b_len           = 0;
    ovf_flag        = 1'b0;
    issued_cnt      = $size(directed_rows);
    accepted_cnt    = 0;
    err_cnt         = 0;
    foreach (directed_rows[k]) stim_q.push_back(directed_rows[k]);
    while (issued_cnt < RandomItems) queue_poly_pair();
    total_cnt = stim_q.size();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_cnt < total_cnt) @(posedge clk_i);
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && sum_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
